// File: hdl/oadc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oadc_pkg
// Shared types, constants and helpers of the obstacle avoidance drive
// controller.
// ----------------------------------------------------------------------------
package oadc_pkg;

    localparam int SPEED_LIMIT_DEF = 150;

    localparam int ECHO_W  = 15;
    localparam int SPEED_W = 8;
    localparam int HOLD_W  = 9;
    localparam int CNT_W   = 4;
    localparam int MAX_CMD = 4;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [ECHO_W-1:0] FAR_ECHO_US = 15'd23530;

    localparam logic [HOLD_W-1:0] HOLD_STOP   = 9'd50;
    localparam logic [HOLD_W-1:0] HOLD_BACKUP = 9'd350;
    localparam logic [HOLD_W-1:0] HOLD_SPIN   = 9'd450;
    localparam logic [HOLD_W-1:0] HOLD_FINAL  = 9'd100;

    // register map, word index
    typedef enum logic [2:0] {
        REG_OBSTACLE_ECHO = 3'd0,
        REG_DEFAULT_TURN  = 3'd1,
        REG_TAPE_CONFIRM  = 3'd2,
        REG_CLEAR_CONFIRM = 3'd3,
        REG_STRAIGHT_SPD  = 3'd4,
        REG_BACKUP_SPD    = 3'd5,
        REG_SPIN_SPD      = 3'd6,
        REG_VIBRATE_BOOST = 3'd7
    } t_reg_idx;

    localparam logic [ECHO_W-1:0]  RST_OBSTACLE_ECHO = 15'd471;
    localparam logic               RST_DEFAULT_TURN  = 1'b1;
    localparam logic [CNT_W-1:0]   RST_TAPE_CONFIRM  = 4'd1;
    localparam logic [CNT_W-1:0]   RST_CLEAR_CONFIRM = 4'd3;
    localparam logic [SPEED_W-1:0] RST_STRAIGHT_SPD  = 8'd130;
    localparam logic [SPEED_W-1:0] RST_BACKUP_SPD    = 8'd100;
    localparam logic [SPEED_W-1:0] RST_SPIN_SPD      = 8'd150;
    localparam logic [SPEED_W-1:0] RST_VIBRATE_BOOST = 8'd15;

    typedef struct packed {
        logic [ECHO_W-1:0]  obstacle_echo_us;
        logic               dflt_spin_left;
        logic [CNT_W-1:0]   tape_confirm_rounds;
        logic [CNT_W-1:0]   clear_confirm_rounds;
        logic [SPEED_W-1:0] drive_speed;
        logic [SPEED_W-1:0] backup_speed;
        logic [SPEED_W-1:0] spin_speed;
        logic [SPEED_W-1:0] vibrate_boost;
    } t_cfg;

    // one motor command before clamp and vibration
    typedef struct packed {
        logic               left_reverse;
        logic [SPEED_W-1:0] left_speed;
        logic               right_reverse;
        logic [SPEED_W-1:0] right_speed;
        logic [HOLD_W-1:0]  hold_ms;
        logic               last;
    } t_cmd;

    typedef struct packed {
        t_cmd [MAX_CMD-1:0] cmds;
        logic [2:0]         cnt;
    } t_batch;

    function automatic t_cmd make_cmd(logic lrev, logic [SPEED_W-1:0] lmag, logic rrev,
                                      logic [SPEED_W-1:0] rmag, logic [HOLD_W-1:0] hold,
                                      logic last);
        t_cmd c;
        c.left_reverse  = lrev;
        c.left_speed    = lmag;
        c.right_reverse = rrev;
        c.right_speed   = rmag;
        c.hold_ms       = hold;
        c.last          = last;
        return c;
    endfunction

    function automatic logic [SPEED_W-1:0] clamp_speed(logic [SPEED_W:0] v,
                                                       logic [SPEED_W:0] limit);
        return (v > limit) ? limit[SPEED_W-1:0] : v[SPEED_W-1:0];
    endfunction

endpackage

// File: hdl/oadc_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oadc_apb_regs
// APB configuration register file, one 32-bit word per register.
// ----------------------------------------------------------------------------
module oadc_apb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [oadc_pkg::ADDR_W-1:0] paddr,
    input  logic [oadc_pkg::DATA_W-1:0] pwdata,
    output logic [oadc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output oadc_pkg::t_cfg             o_cfg
);
    import oadc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_echo_us     <= RST_OBSTACLE_ECHO;
            r_cfg.dflt_spin_left       <= RST_DEFAULT_TURN;
            r_cfg.tape_confirm_rounds  <= RST_TAPE_CONFIRM;
            r_cfg.clear_confirm_rounds <= RST_CLEAR_CONFIRM;
            r_cfg.drive_speed          <= RST_STRAIGHT_SPD;
            r_cfg.backup_speed         <= RST_BACKUP_SPD;
            r_cfg.spin_speed           <= RST_SPIN_SPD;
            r_cfg.vibrate_boost        <= RST_VIBRATE_BOOST;
        end else if (wr_en) begin
            unique case (idx)
                REG_OBSTACLE_ECHO: r_cfg.obstacle_echo_us     <= pwdata[ECHO_W-1:0];
                REG_DEFAULT_TURN:  r_cfg.dflt_spin_left       <= pwdata[0];
                REG_TAPE_CONFIRM:  r_cfg.tape_confirm_rounds  <= pwdata[CNT_W-1:0];
                REG_CLEAR_CONFIRM: r_cfg.clear_confirm_rounds <= pwdata[CNT_W-1:0];
                REG_STRAIGHT_SPD:  r_cfg.drive_speed          <= pwdata[SPEED_W-1:0];
                REG_BACKUP_SPD:    r_cfg.backup_speed         <= pwdata[SPEED_W-1:0];
                REG_SPIN_SPD:      r_cfg.spin_speed           <= pwdata[SPEED_W-1:0];
                REG_VIBRATE_BOOST: r_cfg.vibrate_boost        <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_OBSTACLE_ECHO: prdata = DATA_W'(r_cfg.obstacle_echo_us);
            REG_DEFAULT_TURN:  prdata = DATA_W'(r_cfg.dflt_spin_left);
            REG_TAPE_CONFIRM:  prdata = DATA_W'(r_cfg.tape_confirm_rounds);
            REG_CLEAR_CONFIRM: prdata = DATA_W'(r_cfg.clear_confirm_rounds);
            REG_STRAIGHT_SPD:  prdata = DATA_W'(r_cfg.drive_speed);
            REG_BACKUP_SPD:    prdata = DATA_W'(r_cfg.backup_speed);
            REG_SPIN_SPD:      prdata = DATA_W'(r_cfg.spin_speed);
            REG_VIBRATE_BOOST: prdata = DATA_W'(r_cfg.vibrate_boost);
            default:           prdata = '0;
        endcase
    end

endmodule

// File: hdl/oadc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oadc_round
// Per-round decision: tape confirmation, obstacle trigger, turn side and
// the raw command batch. Holds the avoidance state.
// ----------------------------------------------------------------------------
module oadc_round (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  oadc_pkg::t_cfg              i_cfg,
    input  logic                        i_accept,
    input  logic [1:0]                  i_tape_mask,
    input  logic [oadc_pkg::ECHO_W-1:0] i_center_echo_us,
    input  logic [oadc_pkg::ECHO_W-1:0] i_left_echo_us,
    input  logic [oadc_pkg::ECHO_W-1:0] i_right_echo_us,
    output oadc_pkg::t_batch            o_batch
);
    import oadc_pkg::*;

    logic [CNT_W-1:0] r_lcnt, r_rcnt, r_clear;
    logic             r_turning, r_side_left;
    logic [CNT_W-1:0] n_lcnt, n_rcnt, n_clear;
    logic             n_turning, n_side_left;

    logic [ECHO_W-1:0] c_echo, l_echo, r_echo;
    logic [CNT_W-1:0]  lcnt_up, rcnt_up, clear_up;
    logic              sonic, conf_l, conf_r, trigger, fresh;
    t_cmd              stop_cmd, spin_cmd;

    assign c_echo = (i_center_echo_us == '0) ? FAR_ECHO_US : i_center_echo_us;
    assign l_echo = (i_left_echo_us   == '0) ? FAR_ECHO_US : i_left_echo_us;
    assign r_echo = (i_right_echo_us  == '0) ? FAR_ECHO_US : i_right_echo_us;

    assign sonic = (c_echo < i_cfg.obstacle_echo_us) || (l_echo < i_cfg.obstacle_echo_us)
                || (r_echo < i_cfg.obstacle_echo_us);

    assign lcnt_up = !i_tape_mask[0] ? '0 :
                     (r_lcnt < i_cfg.tape_confirm_rounds) ? r_lcnt + 1'b1 : r_lcnt;
    assign rcnt_up = !i_tape_mask[1] ? '0 :
                     (r_rcnt < i_cfg.tape_confirm_rounds) ? r_rcnt + 1'b1 : r_rcnt;
    assign conf_l  = lcnt_up >= i_cfg.tape_confirm_rounds;
    assign conf_r  = rcnt_up >= i_cfg.tape_confirm_rounds;
    assign trigger = conf_l || conf_r || sonic;
    assign fresh   = !r_turning;
    assign clear_up = r_clear + 1'b1;

    always_comb begin
        n_lcnt      = lcnt_up;
        n_rcnt      = rcnt_up;
        n_clear     = r_clear;
        n_turning   = r_turning;
        n_side_left = r_side_left;
        stop_cmd    = make_cmd(1'b0, '0, 1'b0, '0, HOLD_STOP, 1'b0);
        spin_cmd    = make_cmd(1'b0, '0, 1'b0, '0, HOLD_SPIN, 1'b0);
        o_batch     = '0;
        if (trigger) begin
            n_lcnt    = '0;
            n_rcnt    = '0;
            n_clear   = '0;
            n_turning = 1'b1;
            if (fresh) begin
                if (conf_l && conf_r) begin
                    n_side_left = i_cfg.dflt_spin_left;
                end else if (conf_l) begin
                    n_side_left = 1'b0;
                end else if (conf_r) begin
                    n_side_left = 1'b1;
                end else begin
                    n_side_left = l_echo >= r_echo;
                end
            end
            spin_cmd = make_cmd(n_side_left, i_cfg.spin_speed, !n_side_left,
                                i_cfg.spin_speed, HOLD_SPIN, 1'b0);
            o_batch.cmds[0] = stop_cmd;
            if (fresh) begin
                o_batch.cmds[1] = make_cmd(1'b1, i_cfg.backup_speed, 1'b1,
                                           i_cfg.backup_speed, HOLD_BACKUP, 1'b0);
                o_batch.cmds[2] = spin_cmd;
                o_batch.cmds[3] = make_cmd(1'b0, '0, 1'b0, '0, HOLD_FINAL, 1'b1);
                o_batch.cnt     = 3'd4;
            end else begin
                o_batch.cmds[1] = spin_cmd;
                o_batch.cmds[2] = make_cmd(1'b0, '0, 1'b0, '0, HOLD_FINAL, 1'b1);
                o_batch.cnt     = 3'd3;
            end
        end else begin
            o_batch.cnt     = 3'd1;
            o_batch.cmds[0] = make_cmd(1'b0, i_cfg.drive_speed, 1'b0,
                                       i_cfg.drive_speed, HOLD_STOP, 1'b1);
            if (r_turning) begin
                if (clear_up < i_cfg.clear_confirm_rounds) begin
                    n_clear         = clear_up;
                    o_batch.cmds[0] = make_cmd(1'b0, '0, 1'b0, '0, HOLD_STOP, 1'b1);
                end else begin
                    n_turning = 1'b0;
                    n_clear   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt      <= '0;
            r_rcnt      <= '0;
            r_clear     <= '0;
            r_turning   <= 1'b0;
            r_side_left <= 1'b1;
        end else if (i_accept) begin
            r_lcnt      <= n_lcnt;
            r_rcnt      <= n_rcnt;
            r_clear     <= n_clear;
            r_turning   <= n_turning;
            r_side_left <= n_side_left;
        end
    end

endmodule

// File: hdl/oadc_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oadc_emit
// Batch buffer and output register: sends one command per cycle unless
// stalled, applying the speed clamp and the alternating vibration boost.
// ----------------------------------------------------------------------------
module oadc_emit #(
    parameter int SPEED_LIMIT = oadc_pkg::SPEED_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [oadc_pkg::SPEED_W-1:0] i_vibrate_boost,
    input  logic                         i_batch_valid,
    input  oadc_pkg::t_batch             i_batch,
    output logic                         o_batch_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output oadc_pkg::t_cmd               o_cmd
);
    import oadc_pkg::*;

    localparam logic [SPEED_W:0] LIMIT = (SPEED_W+1)'(SPEED_LIMIT);

    t_cmd [MAX_CMD-1:0] r_cmds;
    logic [2:0]         r_cnt;
    logic [1:0]         r_idx;
    logic               r_valid, r_phase;
    t_cmd               r_out;

    t_cmd               cur, n_out;
    logic               load, take;
    logic [SPEED_W-1:0] lc, rc, lv, rv;

    assign load          = (r_cnt != '0) && (!r_valid || i_ready);
    assign o_batch_ready = (r_cnt == '0) || ((r_cnt == 3'd1) && load);
    assign take          = i_batch_valid && o_batch_ready;
    assign cur           = r_cmds[r_idx];

    always_comb begin
        lc = clamp_speed({1'b0, cur.left_speed}, LIMIT);
        rc = clamp_speed({1'b0, cur.right_speed}, LIMIT);
        lv = lc;
        rv = rc;
        if (!r_phase) begin
            lv = clamp_speed({1'b0, lc} + {1'b0, i_vibrate_boost}, LIMIT);
            rv = clamp_speed({1'b0, rc} + {1'b0, i_vibrate_boost}, LIMIT);
        end
        n_out               = cur;
        n_out.left_speed    = lv;
        n_out.right_speed   = rv;
        n_out.left_reverse  = cur.left_reverse && (lv != '0);
        n_out.right_reverse = cur.right_reverse && (rv != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (take) begin
                r_cnt <= i_batch.cnt;
                r_idx <= '0;
            end else if (load) begin
                r_cnt <= r_cnt - 1'b1;
                r_idx <= r_idx + 1'b1;
            end
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !r_phase;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmds <= i_batch.cmds;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_out;

endmodule

// File: hdl/obstacle_avoidance_drive_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoidance_drive_controller
// Sensing rounds in, sign/magnitude wheel commands out.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// s_axis    in         tvalid/tready             one sensing round
// m_axis    out        tvalid/tready, tlast      one wheel command
// apb       in/out     psel/penable, pready=1    eight config registers
//
// A round is taken in a single s_axis transfer and yields 1, 3 or 4 commands,
// sent one per cycle from the output register while m_axis does not stall.
// The next round is accepted in the cycle its predecessor's last command
// moves into the output register. Output stalls back-pressure s_axis.
// Synchronous active-low reset clears state; config takes its reset values.
// ----------------------------------------------------------------------------
module obstacle_avoidance_drive_controller #(
    parameter int SPEED_LIMIT = oadc_pkg::SPEED_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tape_mask[1:0], center_echo_us[16:2], left_echo_us[31:17],
    // right_echo_us[46:32], zero pad [47]
    input  logic [oadc_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // left_reverse[0], left_speed[8:1], right_reverse[9], right_speed[17:10],
    // hold_ms[26:18], zero pad [31:27]
    output logic [oadc_pkg::OUT_W-1:0]   o_m_axis_tdata,
    output logic                         o_m_axis_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [oadc_pkg::ADDR_W-1:0]  paddr,
    input  logic [oadc_pkg::DATA_W-1:0]  pwdata,
    output logic [oadc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import oadc_pkg::*;

    t_cfg   cfg;
    t_batch batch;
    t_cmd   cmd;
    logic   accept;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    oadc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    oadc_round u_round (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_accept         (accept),
        .i_tape_mask      (i_s_axis_tdata[1:0]),
        .i_center_echo_us (i_s_axis_tdata[16:2]),
        .i_left_echo_us   (i_s_axis_tdata[31:17]),
        .i_right_echo_us  (i_s_axis_tdata[46:32]),
        .o_batch          (batch)
    );

    oadc_emit #(
        .SPEED_LIMIT (SPEED_LIMIT)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vibrate_boost (cfg.vibrate_boost),
        .i_batch_valid   (i_s_axis_tvalid),
        .i_batch         (batch),
        .o_batch_ready   (o_s_axis_tready),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_cmd           (cmd)
    );

    assign o_m_axis_tdata = {5'b0, cmd.hold_ms, cmd.right_speed, cmd.right_reverse,
                             cmd.left_speed, cmd.left_reverse};
    assign o_m_axis_tlast = cmd.last;

endmodule

// File: hdl/oadc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oadc_chk
// Port-level checks of the drive controller, bound to the top level.
// ----------------------------------------------------------------------------
module oadc_chk #(
    parameter int SPEED_LIMIT = oadc_pkg::SPEED_LIMIT_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [oadc_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic                       o_m_axis_tlast
);
    import oadc_pkg::*;

    localparam logic [SPEED_W-1:0] LIMIT = SPEED_W'(SPEED_LIMIT);

    logic [HOLD_W-1:0] hold;
    assign hold = o_m_axis_tdata[26:18];

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled transfer changed");

    a_speed_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[8:1] <= LIMIT && o_m_axis_tdata[17:10] <= LIMIT)
        else $error("speed above limit");

    a_reverse_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tdata[0] || o_m_axis_tdata[8:1] != '0)
                         && (!o_m_axis_tdata[9] || o_m_axis_tdata[17:10] != '0))
        else $error("reverse with zero speed");

    a_hold_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast && (hold == HOLD_STOP || hold == HOLD_FINAL))
            || (!o_m_axis_tlast && (hold == HOLD_STOP || hold == HOLD_BACKUP
                                    || hold == HOLD_SPIN)))
        else $error("bad hold time for command");

endmodule

bind obstacle_avoidance_drive_controller oadc_chk #(
    .SPEED_LIMIT (SPEED_LIMIT)
) u_oadc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
